>>> rtl/core/slm_pkg.sv
// shared types and constants for the sorted list merger
package slm_pkg;

   // field widths
   localparam int VALUE_W = 32;
   localparam int MODE_W  = 2;

   // default list capacity
   localparam int LIST_DEPTH_DEF = 16;

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

endpackage

>>> rtl/core/slm_ram.sv
// generic single-write, single-read ram with registered read data
module slm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sorted_list_merger.sv
// sorted list merger: two list rams and a stable two-way merge sequencer
//
// Requests arrive on the req_ channel (valid/ready). Mode load A or load B
// appends req_value to that list; a load into a full list is
// dropped and sets the overflow flag. Mode merge streams both lists out
// on the rsp_ channel in ascending signed order, list A first on ties,
// with rsp_last on the final value and rsp_overflowed on every value.
// Unused mode codes are taken and ignored.
// Throughput: one load per cycle; a merge emits one value per cycle while
// the receiver is ready, paced by the single read port of each list ram
// (read address follows the next head index). The first value of a merge
// passes the state and output registers. A merge of two empty lists gives
// no response. req_ready is low only while a merge is streaming.
// A stalled receiver holds the output register and pauses the merge; new
// loads are taken while the final value still waits.
// Reset clears the counts, the overflow flag and the controller; the
// list rams are not cleared and need no clearing pass.
module sorted_list_merger #(
   parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [slm_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [slm_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [slm_pkg::VALUE_W-1:0]  rsp_merged_value,
   output logic                                rsp_last,
   output logic                                rsp_overflowed
);
   import slm_pkg::*;

   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int SUM_W  = CNT_W + 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in;
   logic [CNT_W-1:0] idx_b_ff, idx_b_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             wr_a_en, wr_b_en;
   logic [VALUE_W-1:0] head_a, head_b;
   logic             accept, out_free, take_a;
   logic [SUM_W-1:0] total, emitted;

   // list storage
   slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (count_a_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (idx_a_in[ADDR_W-1:0]),
      .rd_data (head_a)
   );

   slm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (count_b_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (idx_b_in[ADDR_W-1:0]),
      .rd_data (head_b)
   );

   // merge bookkeeping
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign total    = SUM_W'(count_a_ff) + SUM_W'(count_b_ff);
   assign emitted  = SUM_W'(idx_a_ff) + SUM_W'(idx_b_ff);
   assign take_a   = (idx_a_ff < count_a_ff) &&
                     ((idx_b_ff >= count_b_ff) || ($signed(head_a) <= $signed(head_b)));

   // next state, loads and merge emission
   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_a_en      = 1'b0;
      wr_b_en      = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_a_in  = '0;
            idx_b_in  = '0;
            if (accept) begin
               unique case (req_mode)
                  MODE_LOAD_A: begin
                     if (count_a_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_a_en    = 1'b1;
                        count_a_in = count_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_LOAD_B: begin
                     if (count_b_ff < CNT_W'(LIST_DEPTH)) begin
                        wr_b_en    = 1'b1;
                        count_b_in = count_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_MERGE: begin
                     if (total == '0) begin
                        ovf_in = 1'b0;
                     end else begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = take_a ? head_a : head_b;
               rsp_last_in  = (emitted + 1'b1) == total;
               rsp_ovf_in   = ovf_ff;
               if (take_a) begin
                  idx_a_in = idx_a_ff + 1'b1;
               end else begin
                  idx_b_in = idx_b_ff + 1'b1;
               end
               // final value: clear the lists and return to idle
               if ((emitted + 1'b1) == total) begin
                  state_in   = ST_IDLE;
                  count_a_in = '0;
                  count_b_in = '0;
                  ovf_in     = 1'b0;
                  idx_a_in   = '0;
                  idx_b_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

>>> rtl/core/slm_checker.sv
// port-level assertions for the sorted list merger, bound to the top level
module slm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [slm_pkg::MODE_W-1:0]          req_mode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [slm_pkg::VALUE_W-1:0]  rsp_merged_value,
   input logic                                rsp_last,
   input logic                                rsp_overflowed
);
   import slm_pkg::*;

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_merged_value) && $stable(rsp_last) && $stable(rsp_overflowed))
      else $error("response payload changed while stalled");

   // a load request never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != MODE_MERGE && !rsp_valid |=> !rsp_valid)
      else $error("response appeared after a load request");

   // no request is taken while a merge is still streaming
   a_merge_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a merge");

endmodule

bind sorted_list_merger slm_checker u_slm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_merged_value (rsp_merged_value),
   .rsp_last         (rsp_last),
   .rsp_overflowed   (rsp_overflowed)
);
